/* rtl/utf8e_pkg.sv */
package utf8e_pkg;

  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [30:0] cp;
    logic [2:0]  len;
    logic        err;
  } entry_t;

  function automatic logic [7:0] lead_mark(input logic [2:0] len);
    logic [7:0] mark;
    unique case (len)
      3'd2:    mark = 8'hC0;
      3'd3:    mark = 8'hE0;
      3'd4:    mark = 8'hF0;
      3'd5:    mark = 8'hF8;
      3'd6:    mark = 8'hFC;
      default: mark = 8'h00;
    endcase
    return mark;
  endfunction

endpackage

/* rtl/utf8e_front.sv */
module utf8e_front (
  input  logic                ascii_single_byte,
  input  logic                in_valid,
  input  logic [31:0]         code_point,
  input  logic                queue_full,
  output logic                in_stall,
  output logic                push,
  output utf8e_pkg::entry_t   entry
);

  logic single;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;
  assign single   = ascii_single_byte && (code_point != 32'd0) && (code_point < 32'h80);

  always_comb begin
    entry.cp  = code_point[30:0];
    entry.err = 1'b0;
    priority if (single) begin
      entry.len = 3'd1;
    end else if (code_point[31]) begin
      entry.len = 3'd1;
      entry.err = 1'b1;
    end else if (code_point < 32'h800) begin
      entry.len = 3'd2;
    end else if (code_point < 32'h10000) begin
      entry.len = 3'd3;
    end else if (code_point < 32'h200000) begin
      entry.len = 3'd4;
    end else if (code_point < 32'h4000000) begin
      entry.len = 3'd5;
    end else begin
      entry.len = 3'd6;
    end
  end

endmodule

/* rtl/utf8e_queue.sv */
module utf8e_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8e_pkg::entry_t wr_data,
  input  logic              pop,
  output logic              full,
  output logic              rd_valid,
  output utf8e_pkg::entry_t rd_data
);

  localparam int unsigned PtrW = (utf8e_pkg::QDepth > 1) ? $clog2(utf8e_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(utf8e_pkg::QDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(utf8e_pkg::QDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(utf8e_pkg::QDepth);

  utf8e_pkg::entry_t mem [utf8e_pkg::QDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_pop;

  assign full     = (count == FullCnt);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/utf8e_back.sv */
module utf8e_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_valid,
  input  utf8e_pkg::entry_t rd_data,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              last_byte,
  output logic              range_error
);

  logic [2:0]  idx;
  logic [2:0]  sel;
  logic [30:0] shifted;
  logic [7:0]  byte_val;
  logic        at_last;
  logic        adv;

  assign adv     = rd_valid && (!out_valid || !out_stall);
  assign at_last = (idx == rd_data.len - 3'd1);
  assign sel     = rd_data.len - 3'd1 - idx;
  assign pop     = adv && at_last;

  always_comb begin
    unique case (sel)
      3'd0:    shifted = rd_data.cp;
      3'd1:    shifted = rd_data.cp >> 6;
      3'd2:    shifted = rd_data.cp >> 12;
      3'd3:    shifted = rd_data.cp >> 18;
      3'd4:    shifted = rd_data.cp >> 24;
      3'd5:    shifted = rd_data.cp >> 30;
      default: shifted = '0;
    endcase
  end

  always_comb begin
    priority if (rd_data.len == 3'd1) begin
      byte_val = rd_data.err ? 8'h00 : rd_data.cp[7:0];
    end else if (idx == 3'd0) begin
      byte_val = utf8e_pkg::lead_mark(rd_data.len) | shifted[7:0];
    end else begin
      byte_val = {2'b10, shifted[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
      idx       <= at_last ? 3'd0 : idx + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= byte_val;
      last_byte   <= at_last;
      range_error <= rd_data.err;
    end
  end

endmodule

/* rtl/utf8_sequence_encoder.sv */
// UTF-8 encoder, original 31-bit form (1 to 6 byte sequences).
// Input channel: in_valid / in_stall with code_point; one request per code point.
// Output channel: out_valid / out_stall with out_byte, last_byte, range_error;
// one request per byte, last_byte set on the final byte of a code point.
// Code points at or above 0x80000000 give a single request with range_error
// set and out_byte zero. With ascii_single_byte set, 1..0x7F go out as one
// plain byte; zero always encodes as C0 80.
// cfg_write loads ascii_single_byte from cfg_data; write only while idle.
// A code point is registered in the queue, and each of its bytes is then
// registered in the output register before it is presented.
// Throughput: one byte per cycle while out_stall is low and the queue holds an
// entry, so a code point takes 1 to 6 bytes; the back-end serialiser sets this.
// A two-entry queue sits between the classifier and the serialiser, so new
// code points are taken while earlier bytes are still going out.
// Reset clears the queue, out_valid and the byte index, and sets ascii_single_byte.
// While out_stall is high the presented byte holds; once the queue fills,
// in_stall rises.
module utf8_sequence_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] code_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic        range_error
);

  logic              ascii_single_byte;
  logic              queue_full;
  logic              push;
  logic              pop;
  logic              rd_valid;
  utf8e_pkg::entry_t wr_entry;
  utf8e_pkg::entry_t rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_single_byte <= 1'b1;
    end else if (cfg_write) begin
      ascii_single_byte <= cfg_data;
    end
  end

  utf8e_front u_front (
    .ascii_single_byte (ascii_single_byte),
    .in_valid          (in_valid),
    .code_point        (code_point),
    .queue_full        (queue_full),
    .in_stall          (in_stall),
    .push              (push),
    .entry             (wr_entry)
  );

  utf8e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (wr_entry),
    .pop      (pop),
    .full     (queue_full),
    .rd_valid (rd_valid),
    .rd_data  (rd_entry)
  );

  utf8e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rd_valid    (rd_valid),
    .rd_data     (rd_entry),
    .out_stall   (out_stall),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .range_error (range_error)
  );

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last_byte && (out_byte == 8'h00))
    else $error("range error not a lone zero byte");

  a_mid_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> out_byte[7] && !range_error)
    else $error("non-final byte is not a lead or continuation byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last_byte)
    else $error("queue entry retired without a final byte");

endmodule

/* sim/utf8_sequence_encoder_test.sv */
`timescale 1ns / 100ps

module utf8_sequence_encoder_test;

  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned SettleTicks = 8;
  localparam int unsigned MaxReports  = 10;

  localparam logic [7:0] MarkTwo   = 8'hC0;
  localparam logic [7:0] MarkThree = 8'hE0;
  localparam logic [7:0] MarkFour  = 8'hF0;
  localparam logic [7:0] MarkFive  = 8'hF8;
  localparam logic [7:0] MarkSix   = 8'hFC;
  localparam logic [7:0] ContMark  = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } utf8_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] code_point = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        range_error;

  logic [31:0] pending_points[$];
  utf8_byte_t  expected_bytes[$];
  logic        ascii_mode = 1'b1;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  int unsigned points_taken = 0;
  int unsigned bytes_checked = 0;
  int unsigned mismatches = 0;
  int unsigned failures = 0;

  utf8_sequence_encoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_point  (code_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .range_error (range_error)
  );

  always #5 clk = ~clk;

  function automatic void push_byte(input logic [7:0] data, input logic last, input logic err);
    utf8_byte_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    expected_bytes.push_back(b);
  endfunction

  function automatic void encode_point(input logic [31:0] cp);
    int unsigned n;
    logic [7:0]  mark;
    logic [31:0] lead;
    logic [31:0] cont;
    if (ascii_mode && cp != 32'd0 && cp < 32'h80) begin
      push_byte(cp[7:0], 1'b1, 1'b0);
      return;
    end
    if (cp[31]) begin
      push_byte(8'h00, 1'b1, 1'b1);
      return;
    end
    if (cp < 32'h800) begin
      n = 2; mark = MarkTwo;
    end else if (cp < 32'h10000) begin
      n = 3; mark = MarkThree;
    end else if (cp < 32'h200000) begin
      n = 4; mark = MarkFour;
    end else if (cp < 32'h4000000) begin
      n = 5; mark = MarkFive;
    end else begin
      n = 6; mark = MarkSix;
    end
    lead = cp >> (6 * (n - 1));
    push_byte(mark | lead[7:0], 1'b0, 1'b0);
    for (int unsigned k = 1; k < n; k++) begin
      cont = (cp >> (6 * (n - 1 - k))) & 32'h3F;
      push_byte(ContMark | cont[7:0], k == n - 1, 1'b0);
    end
  endfunction

  function automatic logic [31:0] random_point();
    case ($urandom_range(7))
      0: begin
        if ($urandom_range(15) == 0) return 32'd0;
        return $urandom_range(32'h7F, 32'h1);
      end
      1: return $urandom_range(32'h7FF, 32'h80);
      2: return $urandom_range(32'hFFFF, 32'h800);
      3: return $urandom_range(32'h1FFFFF, 32'h10000);
      4: return $urandom_range(32'h3FFFFFF, 32'h200000);
      5: return $urandom_range(32'h7FFFFFFF, 32'h4000000);
      6: return $urandom | 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_point(code_point);
        points_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          code_point <= pending_points.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with the occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served < hold_requests) begin
      out_stall    <= 1'b1;
      hold_left    <= HoldCycles;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // byte monitor
  always @(posedge clk) begin
    utf8_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (mismatches < MaxReports)
          $display("unexpected byte %02h last %0b err %0b", out_byte, last_byte, range_error);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data || last_byte !== want.last || range_error !== want.err) begin
          failures++;
          if (mismatches < MaxReports)
            $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.data, want.last, want.err, out_byte, last_byte, range_error);
          mismatches++;
        end
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_points.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(negedge clk);
    repeat (SettleTicks) @(negedge clk);
  endtask

  task automatic write_ascii_mode(input logic v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write  <= 1'b0;
    ascii_mode = v;
    @(negedge clk);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) pending_points.push_back(random_point());
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
  endtask

  initial begin
    logic [31:0] edge_points[17];
    edge_points = '{32'h0, 32'h1, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                    32'h10000, 32'h1FFFFF, 32'h200000, 32'h3FFFFFF, 32'h4000000,
                    32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h55555555,
                    32'hAAAAAAAA};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // boundaries of every sequence length, zero and out of range, reset mode
    foreach (edge_points[i]) pending_points.push_back(edge_points[i]);
    wait_drained();

    // plain ASCII turned off: small values take the two-byte form
    write_ascii_mode(1'b0);
    pending_points.push_back(32'h0);
    pending_points.push_back(32'h1);
    pending_points.push_back(32'h7F);
    pending_points.push_back(32'h80);
    wait_drained();

    write_ascii_mode(1'b1);
    set_idling(0, 0);
    queue_random(97);
    wait_drained();

    write_ascii_mode(1'b0);
    set_idling(51, 0);
    queue_random(97);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    write_ascii_mode(1'b1);
    set_idling(0, 51);
    hold_requests++;
    queue_random(30);
    wait_drained();
    queue_random(67);
    wait_drained();

    write_ascii_mode(1'b0);
    set_idling(27, 27);
    queue_random(50);
    wait_drained();
    queue_random(47);
    wait_drained();

    if (expected_bytes.size() > 0) failures++;
    $display("Encoded %0d code points into %0d checked bytes, %0d mismatches",
             points_taken, bytes_checked, mismatches);
    $display("Both ASCII modes, all sequence lengths, range errors and four stall mixes");
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* utf8_sequence_encoder.f */
rtl/utf8e_pkg.sv
rtl/utf8e_front.sv
rtl/utf8e_queue.sv
rtl/utf8e_back.sv
rtl/utf8_sequence_encoder.sv
sim/utf8_sequence_encoder_test.sv
